>>> hdl/b32d_pkg.sv
// b32d_pkg: shared types and constants for the base32 character decoder.
// No dependencies; used by b32d_result_fifo and base32_char_decoder.
`timescale 1ns / 1ps

package b32d_pkg;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_UC_A  = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;  // 'Z'
  localparam logic [7:0] CHAR_LC_A  = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;  // 'z'
  localparam logic [7:0] CHAR_DIG_2 = 8'h32;  // '2'
  localparam logic [7:0] CHAR_DIG_7 = 8'h37;  // '7'
  localparam logic [4:0] DIGIT_BASE = 5'd26;

  localparam int unsigned STORE_W = 12;
  localparam int unsigned COUNT_W = 4;

  // one decoded result word
  typedef struct packed {
    logic       run_last;
    logic       bad_char;
    logic       message_end;
    logic       byte_valid;
    logic [7:0] out_byte;
  } result_t;

  // write side of the result queue: zero, one or two words per cycle
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

>>> hdl/base32_char_decoder.sv
// base32_char_decoder: top level, base32 text to bytes.
// Depends on b32d_pkg and b32d_result_fifo.
`timescale 1ns / 1ps

// Usage
//   in_*  : one base32 character per word, in_tlast on the message's last one.
//   out_* : decoded results. tdata is the byte, tlast marks message end,
//           tuser flags byte_valid, bad_char and run_last.
//   cfg_* : pad_partial; write only while the block is idle. cfg_ready is 1.
// Each accepted character is decoded in the cycle it is taken: the bit store
// and flags update at that edge and its results (none, one or two) enter a
// small result queue, from which they are handed out on out_* in order. One
// character per cycle is sustained while out_tready stays high and each character
// yields at most one result; a character that yields two (decoded byte plus
// padded final byte) adds a word that must drain through the single output
// port of the queue. in_tready drops only when the queue has no space for two
// more results, so stalls on out_tready back up into in_tready after
// FIFO_DEPTH-1 words. Reset clears the bit store, the flags, the queue and
// pad_partial; no results are pending after reset.
module base32_char_decoder #(
  parameter int unsigned FIFO_DEPTH = 4   // 2 or more
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_char
  input  logic       in_tlast,    // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast,   // message_end
  output logic [2:0] out_tuser,   // [0] byte_valid, [1] bad_char, [2] run_last
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data     // pad_partial
);

  localparam int unsigned SW = b32d_pkg::STORE_W;
  localparam int unsigned CW = b32d_pkg::COUNT_W;

  logic          pad_partial_r;
  logic [SW-1:0] bit_store_r, bit_store_nxt;
  logic [CW-1:0] bit_count_r, bit_count_nxt;
  logic          stopped_r, stopped_nxt;
  logic          error_seen_r, error_seen_nxt;

  logic          in_fire;
  logic          is_pad, is_sym;
  logic [4:0]    sym_val;
  logic [SW-1:0] store_sh, store_dec, store_mask, pad_word;
  logic [CW-1:0] sum_cnt, dec_sh, cnt_new;
  logic [SW-1:0] dec_word;
  logic          take_sym, emit, emit_pad;

  b32d_pkg::result_t res_dec, res_pad, res_empty;
  b32d_pkg::push_t   push;
  b32d_pkg::result_t head;
  logic              room;
  logic              head_valid;

  assign cfg_ready = 1'b1;
  assign in_tready = room;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_partial_r <= 1'b0;
    end else if (cfg_valid) begin
      pad_partial_r <= cfg_data;
    end
  end

  // character classification
  always_comb begin
    is_pad  = (in_tdata == b32d_pkg::CHAR_PAD);
    is_sym  = 1'b1;
    sym_val = '0;
    if (in_tdata inside {[b32d_pkg::CHAR_UC_A : b32d_pkg::CHAR_UC_Z]}) begin
      sym_val = 5'(in_tdata - b32d_pkg::CHAR_UC_A);
    end else if (in_tdata inside {[b32d_pkg::CHAR_DIG_2 : b32d_pkg::CHAR_DIG_7]}) begin
      sym_val = 5'(in_tdata - b32d_pkg::CHAR_DIG_2) + b32d_pkg::DIGIT_BASE;
    end else if (in_tdata inside {[b32d_pkg::CHAR_LC_A : b32d_pkg::CHAR_LC_Z]}) begin
      sym_val = 5'(in_tdata - b32d_pkg::CHAR_LC_A);
    end else begin
      is_sym = 1'b0;
    end
  end

  // shift-in and byte extraction
  always_comb begin
    take_sym   = !stopped_r && !is_pad && is_sym;
    store_sh   = {bit_store_r[SW-6:0], sym_val};
    sum_cnt    = bit_count_r + CW'(5);
    emit       = take_sym && (sum_cnt >= CW'(8));
    dec_sh     = sum_cnt - CW'(8);
    dec_word   = store_sh >> dec_sh;
    store_mask = (SW'(1) << dec_sh) - SW'(1);
    store_dec  = store_sh & store_mask;

    if (!take_sym) begin
      cnt_new       = bit_count_r;
      bit_store_nxt = bit_store_r;
    end else if (emit) begin
      cnt_new       = dec_sh;
      bit_store_nxt = store_dec;
    end else begin
      cnt_new       = sum_cnt;
      bit_store_nxt = store_sh;
    end

    stopped_nxt    = stopped_r || is_pad || !is_sym;
    error_seen_nxt = error_seen_r || (!stopped_r && !is_pad && !is_sym);

    // leftover bits sit in the high end of the padded byte
    pad_word = bit_store_nxt << (CW'(8) - cnt_new);
    emit_pad = in_tlast && pad_partial_r && !stopped_nxt && (cnt_new != '0);
    bit_count_nxt = cnt_new;
  end

  // result assembly: message end and run_last go on the final word
  always_comb begin
    res_dec   = '{run_last: 1'b0, bad_char: 1'b0, message_end: 1'b0,
                  byte_valid: 1'b1, out_byte: dec_word[7:0]};
    res_pad   = '{run_last: 1'b0, bad_char: 1'b0, message_end: 1'b0,
                  byte_valid: 1'b1, out_byte: pad_word[7:0]};
    res_empty = '{run_last: 1'b0, bad_char: 1'b0, message_end: 1'b0,
                  byte_valid: 1'b0, out_byte: 8'd0};
    push = '{count: 2'd0, first: res_empty, second: res_empty};

    if (emit && emit_pad) begin
      push.count  = 2'd2;
      push.first  = res_dec;
      push.second = res_pad;
    end else if (emit) begin
      push.count = 2'd1;
      push.first = res_dec;
    end else if (emit_pad) begin
      push.count = 2'd1;
      push.first = res_pad;
    end else if (in_tlast) begin
      push.count = 2'd1;
    end

    if (push.count == 2'd2) begin
      push.second.run_last    = 1'b1;
      push.second.message_end = 1'b1;
      push.second.bad_char    = error_seen_nxt;
    end else begin
      push.first.run_last    = 1'b1;
      push.first.message_end = in_tlast;
      push.first.bad_char    = in_tlast && error_seen_nxt;
    end

    if (!in_fire) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_store_r  <= '0;
      bit_count_r  <= '0;
      stopped_r    <= 1'b0;
      error_seen_r <= 1'b0;
    end else if (in_fire) begin
      if (in_tlast) begin
        bit_store_r  <= '0;
        bit_count_r  <= '0;
        stopped_r    <= 1'b0;
        error_seen_r <= 1'b0;
      end else begin
        bit_store_r  <= bit_store_nxt;
        bit_count_r  <= bit_count_nxt;
        stopped_r    <= stopped_nxt;
        error_seen_r <= error_seen_nxt;
      end
    end
  end

  b32d_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (out_tready)
  );

  assign out_tvalid = head_valid;
  assign out_tdata  = head.out_byte;
  assign out_tlast  = head.message_end;
  assign out_tuser  = {head.run_last, head.bad_char, head.byte_valid};

  // message end is always the last word of its character
  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[2])
    else $error("message end without run_last");

  // error flag only rides on the message-end word
  a_bad_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("bad_char outside message end");

  // a word without a byte carries zero and closes the message
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata == 8'd0) && out_tlast)
    else $error("empty result malformed");

  // the bit store never holds a full byte between characters
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r < CW'(8))
    else $error("bit count out of range");

  // a character closing the message leaves clean state behind
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> (bit_count_r == '0) && !stopped_r && !error_seen_r)
    else $error("state not cleared after message end");

endmodule

>>> hdl/b32d_result_fifo.sv
// b32d_result_fifo: small result queue that takes up to two words per cycle
// and hands out one. Depends on b32d_pkg (result_t, push_t).
`timescale 1ns / 1ps

module b32d_result_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  b32d_pkg::push_t   push,
  output logic              room,       // space for two more words
  output logic              head_valid,
  output b32d_pkg::result_t head,
  input  logic              pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b32d_pkg::result_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;
  logic             do_pop;

  assign wr_ptr_p1  = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
  assign do_pop     = pop && (cnt_r != '0);
  assign head_valid = (cnt_r != '0);
  assign room       = (cnt_r <= CNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_p1] <= push.second;
    end
  end

  assign head = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    case (push.count)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = (wr_ptr_p1 == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_p1 + PTR_W'(1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(push.count) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> sim/tb_base32_char_decoder.sv
// tb_base32_char_decoder: self-checking testbench for the base32 character decoder.
// Depends on b32d_pkg and base32_char_decoder; predicts each result word and
// checks it against the block under random idling and back-pressure.
`timescale 1ns / 1ps

module tb_base32_char_decoder;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES = 8;

  // out_tuser bit positions
  localparam int USER_BYTE_VALID = 0;
  localparam int USER_BAD_CHAR   = 1;
  localparam int USER_RUN_LAST   = 2;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;
  typedef enum logic [1:0] {MSG_CLEAN, MSG_PADDED, MSG_BAD, MSG_NOISE} msg_kind_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [2:0] out_tuser;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  // decoder model state
  logic        pad_mode;
  logic [11:0] acc_bits;
  logic [3:0]  acc_count;
  logic        halted;
  logic        saw_bad;

  b32d_pkg::result_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // sender / receiver behavior
  logic        gaps_on = 1'b0;
  int unsigned burst_left = 0;
  rx_mode_t    rx_mode = RX_ALWAYS;
  logic [7:0]  stall_pattern = 8'hFF;
  logic        hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned chars_sent = 0;

  base32_char_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // {valid, 5-bit value}
  function automatic logic [5:0] symbol_lookup(input logic [7:0] ch);
    if (ch >= b32d_pkg::CHAR_UC_A && ch <= b32d_pkg::CHAR_UC_Z)
      return {1'b1, 5'(ch - b32d_pkg::CHAR_UC_A)};
    if (ch >= b32d_pkg::CHAR_DIG_2 && ch <= b32d_pkg::CHAR_DIG_7)
      return {1'b1, 5'(ch - b32d_pkg::CHAR_DIG_2) + b32d_pkg::DIGIT_BASE};
    if (ch >= b32d_pkg::CHAR_LC_A && ch <= b32d_pkg::CHAR_LC_Z)
      return {1'b1, 5'(ch - b32d_pkg::CHAR_LC_A)};
    return 6'd0;
  endfunction

  function automatic logic [7:0] rand_symbol();
    case ($urandom_range(0, 2))
      0: return b32d_pkg::CHAR_UC_A + 8'($urandom_range(0, 25));
      1: return b32d_pkg::CHAR_LC_A + 8'($urandom_range(0, 25));
      default: return b32d_pkg::CHAR_DIG_2 + 8'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] rand_bad_char();
    logic [7:0] c;
    logic [5:0] s;
    do begin
      c = 8'($urandom_range(0, 255));
      s = symbol_lookup(c);
    end while (s[5] || c == b32d_pkg::CHAR_PAD);
    return c;
  endfunction

  task automatic clear_message();
    acc_bits = '0;
    acc_count = '0;
    halted = 1'b0;
    saw_bad = 1'b0;
  endtask

  // expected words for one accepted character
  task automatic decode_char(input logic [7:0] ch, input logic last);
    b32d_pkg::result_t slot[2];
    int         n;
    logic [5:0] sym;
    n = 0;
    slot[0] = '0;
    slot[1] = '0;
    sym = symbol_lookup(ch);
    if (!halted) begin
      if (ch == b32d_pkg::CHAR_PAD) begin
        halted = 1'b1;
      end else if (!sym[5]) begin
        saw_bad = 1'b1;
        halted = 1'b1;
      end else begin
        acc_bits = {acc_bits[6:0], sym[4:0]};
        acc_count = acc_count + 4'd5;
        if (acc_count >= 4'd8) begin
          slot[n].byte_valid = 1'b1;
          slot[n].out_byte = 8'(acc_bits >> (acc_count - 4'd8));
          n++;
          acc_count = acc_count - 4'd8;
          acc_bits = acc_bits & ((12'd1 << acc_count) - 12'd1);
        end
      end
    end
    if (last) begin
      if (pad_mode && !halted && acc_count != 0) begin
        slot[n].byte_valid = 1'b1;
        slot[n].out_byte = 8'(acc_bits << (4'd8 - acc_count));
        n++;
      end
      if (n == 0) n = 1;  // bare end-of-message word
      slot[n-1].message_end = 1'b1;
      slot[n-1].bad_char = saw_bad;
      clear_message();
    end
    if (n > 0) slot[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(slot[i]);
  endtask

  task automatic check_result();
    b32d_pkg::result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected word: byte %0h tuser %0b tlast %0b", out_tdata, out_tuser, out_tlast);
      mismatch_count++;
      return;
    end
    want = pending_results.pop_front();
    if (out_tdata !== want.out_byte) begin
      $error("out_byte: expected %0h, got %0h", want.out_byte, out_tdata);
      mismatch_count++;
    end
    if (out_tuser[USER_BYTE_VALID] !== want.byte_valid) begin
      $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_tuser[USER_BYTE_VALID]);
      mismatch_count++;
    end
    if (out_tlast !== want.message_end) begin
      $error("message_end: expected %0b, got %0b", want.message_end, out_tlast);
      mismatch_count++;
    end
    if (out_tuser[USER_BAD_CHAR] !== want.bad_char) begin
      $error("bad_char: expected %0b, got %0b", want.bad_char, out_tuser[USER_BAD_CHAR]);
      mismatch_count++;
    end
    if (out_tuser[USER_RUN_LAST] !== want.run_last) begin
      $error("run_last: expected %0b, got %0b", want.run_last, out_tuser[USER_RUN_LAST]);
      mismatch_count++;
    end
  endtask

  // receiver: check accepted words, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_RANDOM:  out_tready <= ($urandom_range(0, 2) != 0);
        RX_PATTERN: out_tready <= stall_pattern[cycle_count[2:0]];
        default:    out_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic last);
    in_tvalid <= 1'b1;
    in_tdata <= ch;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_char(ch, last);
    chars_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(0, 15);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(8'(s[i]), i == s.len() - 1);
  endtask

  // idle point: every word back, then a settle wait for results-free words
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pad(input logic value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pad_mode = value;
  endtask

  task automatic test_directed_pad_off();
    write_pad(1'b0);
    gaps_on = 1'b0;
    rx_mode = RX_ALWAYS;
    send_text("A");          // end word without a byte
    send_text("Zz7");        // one byte, leftover dropped
    send_text("a2=B");       // pad stops decoding
    send_char(8'h00, 1'b0);  // bad char mid-message
    send_char("Q", 1'b1);
    send_char("Q", 1'b0);
    send_char(8'hFF, 1'b1);  // bad char as last one
  endtask

  task automatic test_directed_pad_on();
    write_pad(1'b1);
    send_text("ABCD");       // byte plus padded byte on one char
    send_text("Ab=");        // pad suppresses padded byte
    send_text("8");          // bad char, no padded byte
  endtask

  task automatic test_random_messages(input logic pad, input rx_mode_t mode,
                                      input logic gaps, input int unsigned n_chars);
    int unsigned target;
    int unsigned len;
    msg_kind_t   kind;
    int unsigned r;
    write_pad(pad);
    rx_mode = mode;
    gaps_on = gaps;
    stall_pattern = 8'($urandom_range(1, 255));
    target = chars_sent + n_chars;
    while (chars_sent < target) begin
      r = $urandom_range(0, 9);
      kind = (r < 6) ? MSG_CLEAN : (r < 8) ? MSG_PADDED : (r < 9) ? MSG_BAD : MSG_NOISE;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      case (kind)
        MSG_CLEAN: begin
          for (int i = 0; i < len; i++) send_char(rand_symbol(), i == len - 1);
        end
        MSG_PADDED: begin
          for (int i = 0; i < len; i++) send_char(rand_symbol(), 1'b0);
          send_char(b32d_pkg::CHAR_PAD, 1'b0);
          r = $urandom_range(0, 4);
          for (int i = 0; i < r; i++)
            send_char(($urandom_range(0, 1) != 0) ? b32d_pkg::CHAR_PAD :
                      8'($urandom_range(0, 255)), 1'b0);
          send_char(b32d_pkg::CHAR_PAD, 1'b1);
        end
        MSG_BAD: begin
          r = $urandom_range(0, len - 1);
          for (int i = 0; i < len; i++)
            send_char((i == r) ? rand_bad_char() : rand_symbol(), i == len - 1);
        end
        default: begin
          for (int i = 0; i < len; i++) send_char(8'($urandom_range(0, 255)), i == len - 1);
        end
      endcase
    end
  endtask

  task automatic test_input_stall();
    write_pad(1'b1);
    rx_mode = RX_ALWAYS;
    gaps_on = 1'b0;
    hold_request = 1'b1;
    // keep offering words; the queue fills and in_tready drops
    for (int i = 0; i < 60; i++) send_char(rand_symbol(), ((i % 7) == 6) || (i == 59));
  endtask

  initial begin
    pad_mode = 1'b0;
    clear_message();
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_pad_off();
    test_directed_pad_on();
    test_random_messages(1'b0, RX_RANDOM,  1'b1, 460);
    test_random_messages(1'b1, RX_PATTERN, 1'b1, 460);
    test_input_stall();
    test_random_messages(1'b0, RX_ALWAYS,  1'b0, 460);
    test_random_messages(1'b1, RX_RANDOM,  1'b1, 460);

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
